FILE: rtl/core/cmft_pkg.sv
// Shared types and constants for the cell monitor fault trip block.
// Payload structs, threshold set, counter entry and the saturating bump.
// No dependencies.
package cmft_pkg;

	localparam int VAL_W = 10;
	localparam int SENSOR_W = 4;
	localparam int CNT_W = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLT_HIGH_WARN       = 3'd0,
		REG_VOLT_HIGH_ERROR      = 3'd1,
		REG_VOLT_LOW_WARN        = 3'd2,
		REG_VOLT_LOW_ERROR       = 3'd3,
		REG_TEMP_CHARGE_WARN     = 3'd4,
		REG_TEMP_CHARGE_ERROR    = 3'd5,
		REG_TEMP_DISCHARGE_WARN  = 3'd6,
		REG_TEMP_DISCHARGE_ERROR = 3'd7
	} cmft_reg_t;

	localparam logic [VAL_W-1:0] RST_VOLT_HIGH_WARN       = 10'd818;
	localparam logic [VAL_W-1:0] RST_VOLT_HIGH_ERROR      = 10'd860;
	localparam logic [VAL_W-1:0] RST_VOLT_LOW_WARN        = 10'd717;
	localparam logic [VAL_W-1:0] RST_VOLT_LOW_ERROR       = 10'd573;
	localparam logic [VAL_W-1:0] RST_TEMP_CHARGE_WARN     = 10'd225;
	localparam logic [VAL_W-1:0] RST_TEMP_CHARGE_ERROR    = 10'd240;
	localparam logic [VAL_W-1:0] RST_TEMP_DISCHARGE_WARN  = 10'd225;
	localparam logic [VAL_W-1:0] RST_TEMP_DISCHARGE_ERROR = 10'd240;

	typedef struct packed {
		logic [SENSOR_W-1:0] sensor_index;
		logic [VAL_W-1:0]    volt_reading;
		logic [VAL_W-1:0]    temp_reading;
		logic                discharging;
		logic                scan_start;
	} cmft_req_t;

	typedef struct packed {
		logic                hv_flag;
		logic                lv_flag;
		logic                ht_flag;
		logic                err_flag;
		logic                tripped;
		logic [VAL_W-1:0]    max_volt;
		logic [SENSOR_W-1:0] max_volt_index;
		logic [VAL_W-1:0]    min_volt;
		logic [SENSOR_W-1:0] min_volt_index;
		logic [VAL_W-1:0]    max_temp;
		logic [SENSOR_W-1:0] max_temp_index;
	} cmft_rsp_t;

	typedef struct packed {
		logic [VAL_W-1:0] volt_high_warn;
		logic [VAL_W-1:0] volt_high_error;
		logic [VAL_W-1:0] volt_low_warn;
		logic [VAL_W-1:0] volt_low_error;
		logic [VAL_W-1:0] temp_charge_warn;
		logic [VAL_W-1:0] temp_charge_error;
		logic [VAL_W-1:0] temp_discharge_warn;
		logic [VAL_W-1:0] temp_discharge_error;
	} cmft_thr_t;

	typedef struct packed {
		logic hv_flag;
		logic lv_flag;
		logic ht_flag;
		logic err_flag;
	} cmft_class_t;

	// one memory word: the three fault counters of a sensor
	typedef struct packed {
		logic [CNT_W-1:0] over_volt;
		logic [CNT_W-1:0] under_volt;
		logic [CNT_W-1:0] over_temp;
	} cmft_cnt_t;

	typedef struct packed {
		logic [VAL_W-1:0]    max_volt;
		logic [SENSOR_W-1:0] max_volt_index;
		logic [VAL_W-1:0]    min_volt;
		logic [SENSOR_W-1:0] min_volt_index;
		logic [VAL_W-1:0]    max_temp;
		logic [SENSOR_W-1:0] max_temp_index;
	} cmft_ext_t;

	function automatic logic [CNT_W-1:0] cnt_bump(input logic [CNT_W-1:0] c, input logic up);
		logic [CNT_W-1:0] r;
		r = c;
		if (up) begin
			if (c != CNT_MAX) r = c + CNT_W'(1);
		end else begin
			if (c != '0) r = c - CNT_W'(1);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/cmft_classify.sv
// Threshold compares for one reading: warning classes and the shared error flag.
// Depends on cmft_pkg.
module cmft_classify
	import cmft_pkg::*;
(
	input  cmft_thr_t   thr,
	input  cmft_req_t   item,
	output cmft_class_t cls
);

	logic [VAL_W-1:0] t_warn;
	logic [VAL_W-1:0] t_err;
	logic             vh, vl, th;
	logic             vh_err, vl_err, th_err;

	always_comb begin
		t_warn = item.discharging ? thr.temp_discharge_warn : thr.temp_charge_warn;
		t_err  = item.discharging ? thr.temp_discharge_error : thr.temp_charge_error;
		// high test wins; low is only looked at below the high warning
		vh     = item.volt_reading >= thr.volt_high_warn;
		vh_err = vh && (item.volt_reading >= thr.volt_high_error);
		vl     = !vh && (item.volt_reading <= thr.volt_low_warn);
		vl_err = vl && (item.volt_reading <= thr.volt_low_error);
		th     = item.temp_reading >= t_warn;
		th_err = th && (item.temp_reading >= t_err);
		cls.hv_flag  = vh;
		cls.lv_flag  = vl;
		cls.ht_flag  = th;
		cls.err_flag = vh_err || vl_err || th_err;
	end

endmodule

FILE: rtl/core/cmft_fault_mem.sv
// Per-sensor fault counter memory: synchronous read at accept, update and
// write-back on upd_en, with forwarding of the write to a same-sensor read.
// Depends on cmft_pkg.
module cmft_fault_mem
	import cmft_pkg::*;
#(
	parameter int NUM_SENSORS = 16,
	parameter int FAULT_LIMIT = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [SENSOR_W-1:0] rd_sensor,
	input  logic                upd_en,
	input  logic [SENSOR_W-1:0] upd_sensor,
	input  cmft_class_t         upd_cls,
	output logic                trip_hit
);

	localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam int WIDE_W = 7;
	localparam logic [WIDE_W-1:0] NUM_W = WIDE_W'(NUM_SENSORS);
	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(FAULT_LIMIT);

	cmft_cnt_t        mem [NUM_SENSORS];
	logic [NUM_SENSORS-1:0] vld_q;

	cmft_cnt_t        mem_rd_s1;
	cmft_cnt_t        fwd_data_s1;
	logic             fwd_s1;
	logic             vld_s1;

	logic [WIDE_W-1:0] rd_wide, wr_wide;
	logic [IDX_W-1:0]  raddr, waddr;
	logic              wr_in_range, wr_en;
	cmft_cnt_t         cur, nxt;

	assign rd_wide     = WIDE_W'(rd_sensor);
	assign wr_wide     = WIDE_W'(upd_sensor);
	assign raddr       = rd_wide[IDX_W-1:0];
	assign waddr       = wr_wide[IDX_W-1:0];
	assign wr_in_range = wr_wide < NUM_W;
	assign wr_en       = upd_en && wr_in_range;

	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= nxt;
		if (rd_en) begin
			mem_rd_s1   <= mem[raddr];
			fwd_data_s1 <= nxt;
		end
	end

	// never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (wr_en) vld_q[waddr] <= 1'b1;
			if (rd_en) begin
				vld_s1 <= vld_q[raddr];
				fwd_s1 <= wr_en && (waddr == raddr);
			end
		end
	end

	always_comb begin
		if (fwd_s1) cur = fwd_data_s1;
		else if (vld_s1) cur = mem_rd_s1;
		else cur = '0;
		nxt = cur;
		if (upd_cls.hv_flag) nxt.over_volt = cnt_bump(cur.over_volt, upd_cls.err_flag);
		if (upd_cls.lv_flag) nxt.under_volt = cnt_bump(cur.under_volt, upd_cls.err_flag);
		if (upd_cls.ht_flag) nxt.over_temp = cnt_bump(cur.over_temp, upd_cls.err_flag);
		trip_hit = wr_in_range && upd_cls.err_flag &&
			((nxt.over_volt >= LIMIT) || (nxt.under_volt >= LIMIT) ||
			 (nxt.over_temp >= LIMIT));
	end

endmodule

FILE: rtl/core/cmft_extremes.sv
// Scan extremes: max and min voltage and max temperature with sensor indices.
// Gives the values after the current reading; commits them on update.
// Depends on cmft_pkg.
module cmft_extremes
	import cmft_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      upd_en,
	input  cmft_req_t item,
	output cmft_ext_t ext_nxt
);

	cmft_ext_t ext_q;

	always_comb begin
		ext_nxt = ext_q;
		if (item.scan_start) begin
			ext_nxt.max_volt       = item.volt_reading;
			ext_nxt.min_volt       = item.volt_reading;
			ext_nxt.max_temp       = item.temp_reading;
			ext_nxt.max_volt_index = item.sensor_index;
			ext_nxt.min_volt_index = item.sensor_index;
			ext_nxt.max_temp_index = item.sensor_index;
		end else begin
			// strict compares: ties keep the earlier sensor
			if (item.volt_reading > ext_q.max_volt) begin
				ext_nxt.max_volt       = item.volt_reading;
				ext_nxt.max_volt_index = item.sensor_index;
			end
			if (item.volt_reading < ext_q.min_volt) begin
				ext_nxt.min_volt       = item.volt_reading;
				ext_nxt.min_volt_index = item.sensor_index;
			end
			if (item.temp_reading > ext_q.max_temp) begin
				ext_nxt.max_temp       = item.temp_reading;
				ext_nxt.max_temp_index = item.sensor_index;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q.max_volt       <= '0;
			ext_q.max_volt_index <= '0;
			ext_q.min_volt       <= VAL_MAX;
			ext_q.min_volt_index <= '0;
			ext_q.max_temp       <= '0;
			ext_q.max_temp_index <= '0;
		end else if (upd_en) begin
			ext_q <= ext_nxt;
		end
	end

endmodule

FILE: rtl/core/cell_monitor_fault_trip_core.sv
// Cell monitor fault trip: top level. Threshold registers, stage 1, trip latch
// and result register. Depends on cmft_pkg, cmft_classify, cmft_fault_mem,
// cmft_extremes.
//
// Use: one cell reading per transfer on req (valid/stall), one result per
// reading on rsp (valid/stall), in order. The user is to write thresholds through
// cfg_wr_en/cfg_index/cfg_data only while the block holds no reading (not enforced).
// Timing: a reading reads its sensor's counter word at the edge that accepts it;
// the counters are updated and written back, and the result is loaded into the
// rsp register, at the edge where it leaves stage 1. One reading per cycle is
// sustained while rsp is not stalled; the counter memory's single read and
// write port sets this; a same-sensor write is forwarded to the following read.
// Stall: rsp holds while stalled. One more reading is still taken into stage 1
// and held there; req_stall rises once stage 1 is full and cannot move on.
// Reset: thresholds take their defaults, counters read as zero (per-entry
// valid bits), trip latch clears, extremes start at max 0 / min 1023. No
// clearing pass; the block takes readings right after reset.
module cell_monitor_fault_trip_core
	import cmft_pkg::*;
#(
	parameter int NUM_SENSORS = 16,
	parameter int FAULT_LIMIT = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  cmft_req_t            req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output cmft_rsp_t            rsp,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data
);

	cmft_thr_t   thr_q;
	logic        s1_valid_q;
	cmft_req_t   item_s1;
	logic        trip_q;
	cmft_rsp_t   rsp_q;
	logic        rsp_valid_q;

	logic        accept, s1_adv, trip_hit, trip_nxt;
	cmft_class_t cls;
	cmft_ext_t   ext_nxt;

	assign s1_adv    = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_q && !s1_adv;
	assign accept    = req_valid && !req_stall;
	assign trip_nxt  = trip_q || trip_hit;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.volt_high_warn       <= RST_VOLT_HIGH_WARN;
			thr_q.volt_high_error      <= RST_VOLT_HIGH_ERROR;
			thr_q.volt_low_warn        <= RST_VOLT_LOW_WARN;
			thr_q.volt_low_error       <= RST_VOLT_LOW_ERROR;
			thr_q.temp_charge_warn     <= RST_TEMP_CHARGE_WARN;
			thr_q.temp_charge_error    <= RST_TEMP_CHARGE_ERROR;
			thr_q.temp_discharge_warn  <= RST_TEMP_DISCHARGE_WARN;
			thr_q.temp_discharge_error <= RST_TEMP_DISCHARGE_ERROR;
		end else if (cfg_wr_en) begin
			unique case (cmft_reg_t'(cfg_index))
				REG_VOLT_HIGH_WARN:       thr_q.volt_high_warn       <= cfg_data;
				REG_VOLT_HIGH_ERROR:      thr_q.volt_high_error      <= cfg_data;
				REG_VOLT_LOW_WARN:        thr_q.volt_low_warn        <= cfg_data;
				REG_VOLT_LOW_ERROR:       thr_q.volt_low_error       <= cfg_data;
				REG_TEMP_CHARGE_WARN:     thr_q.temp_charge_warn     <= cfg_data;
				REG_TEMP_CHARGE_ERROR:    thr_q.temp_charge_error    <= cfg_data;
				REG_TEMP_DISCHARGE_WARN:  thr_q.temp_discharge_warn  <= cfg_data;
				REG_TEMP_DISCHARGE_ERROR: thr_q.temp_discharge_error <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			trip_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) s1_valid_q <= 1'b1;
			else if (s1_adv) s1_valid_q <= 1'b0;
			if (s1_adv) begin
				trip_q      <= trip_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.hv_flag        <= cls.hv_flag;
			rsp_q.lv_flag        <= cls.lv_flag;
			rsp_q.ht_flag        <= cls.ht_flag;
			rsp_q.err_flag       <= cls.err_flag;
			rsp_q.tripped        <= trip_nxt;
			rsp_q.max_volt       <= ext_nxt.max_volt;
			rsp_q.max_volt_index <= ext_nxt.max_volt_index;
			rsp_q.min_volt       <= ext_nxt.min_volt;
			rsp_q.min_volt_index <= ext_nxt.min_volt_index;
			rsp_q.max_temp       <= ext_nxt.max_temp;
			rsp_q.max_temp_index <= ext_nxt.max_temp_index;
		end
	end

	cmft_classify u_classify (
		.thr  (thr_q),
		.item (item_s1),
		.cls  (cls)
	);

	cmft_fault_mem #(
		.NUM_SENSORS (NUM_SENSORS),
		.FAULT_LIMIT (FAULT_LIMIT)
	) u_fault_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_sensor  (req.sensor_index),
		.upd_en     (s1_adv),
		.upd_sensor (item_s1.sensor_index),
		.upd_cls    (cls),
		.trip_hit   (trip_hit)
	);

	cmft_extremes u_extremes (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd_en  (s1_adv),
		.item    (item_s1),
		.ext_nxt (ext_nxt)
	);

	a_trip_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		trip_q |=> trip_q)
		else $error("trip latch cleared without reset");

	a_rsp_trip_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.tripped == trip_q))
		else $error("pending result disagrees with trip latch");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && rsp_valid_q && rsp_stall) |-> req_stall)
		else $error("reading taken while stage 1 is blocked");

	a_err_needs_class: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.hv_flag && !rsp_q.lv_flag && !rsp_q.ht_flag)
		|-> !rsp_q.err_flag)
		else $error("error flagged with no warning class");

endmodule
